>>> sv/sri_pkg.sv
// Package: shared types and constants for the strided run index map.
`default_nettype none
package sri_pkg;
	localparam int MaxRuns   = 64;
	localparam int IdxW      = 32;
	localparam int CntW      = $clog2(MaxRuns + 1);
	localparam int PtrW      = $clog2(MaxRuns);

	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_POS    = 2'd1;
	localparam logic [1:0] KIND_SRC    = 2'd2;
	localparam logic [1:0] KIND_NOP    = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_RANGE    = 3'd1;
	localparam logic [2:0] ST_BEFORE   = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	typedef struct packed {
		logic [1:0]      kind;
		logic [IdxW-1:0] run_start;
		logic [IdxW-1:0] run_length;
		logic [IdxW-1:0] run_stride;
		logic [IdxW-1:0] query_position;
		logic [IdxW-1:0] query_source;
	} in_word_t;

	typedef struct packed {
		logic [IdxW-1:0] source_out;
		logic [IdxW-1:0] position_out;
		logic            contained;
		logic [2:0]      status;
		logic            merged;
		logic [6:0]      run_count_out;
		logic [IdxW-1:0] total_out;
		logic            is_unit_single;
	} out_word_t;

	// one table entry
	typedef struct packed {
		logic [IdxW-1:0] start;
		logic [IdxW-1:0] len;
		logic [IdxW-1:0] stride;
		logic [IdxW-1:0] base;
	} run_t;

	// scan token handed cell to cell
	typedef struct packed {
		logic            vld;
		logic [1:0]      kind;
		logic [IdxW-1:0] key;
		logic            hit;
		run_t            run;
	} scan_t;
endpackage
`default_nettype wire

>>> sv/sri_cell.sv
// Cell: holds one run and updates the scan token as it passes.
`default_nettype none
module sri_cell import sri_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr,
	input  wire run_t  wr_run,
	input  wire logic  occupied,
	input  wire scan_t tok_in,
	output scan_t      tok_out,
	output run_t       run_q
);
	logic            take;
	logic            vld_q;
	logic [1:0]      kind_q;
	logic [IdxW-1:0] key_q;
	logic            hit_q;
	run_t            carry_q;

	assign tok_out = '{vld: vld_q, kind: kind_q, key: key_q, hit: hit_q, run: carry_q};

	always_ff @(posedge clk) begin
		if (wr) run_q <= wr_run;
	end

	// last run whose key field <= query wins; token passes in table order
	always_comb begin
		take = 1'b0;
		if (occupied) begin
			if (tok_in.kind == KIND_POS) take = run_q.base <= tok_in.key;
			else                         take = run_q.start <= tok_in.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		kind_q  <= tok_in.kind;
		key_q   <= tok_in.key;
		hit_q   <= tok_in.hit | take;
		carry_q <= take ? run_q : tok_in.run;
	end
endmodule
`default_nettype wire

>>> sv/sri_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module sri_div import sri_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [IdxW-1:0] num,
	input  wire logic [IdxW-1:0] den,
	output logic                 done,
	output logic [IdxW-1:0]      quo,
	output logic [IdxW-1:0]      rem
);
	localparam int CW = $clog2(IdxW + 1);
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic [IdxW-1:0] den_q;
	logic [IdxW:0]   trial;

	assign trial = {rem, quo[IdxW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(IdxW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo   <= num;
			rem   <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[IdxW]) begin
				rem <= trial[IdxW-1:0];
				quo <= {quo[IdxW-2:0], 1'b1};
			end else begin
				rem <= {rem[IdxW-2:0], quo[IdxW-1]};
				quo <= {quo[IdxW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/strided_run_index_map.sv
// Top level: strided run table as a chain of cells with a serial divider.
// Append: merge check multiply, then update; a no-op is answered straight from idle.
// Position query: chain sweep through every cell, then multiply-add; out of range ends at the sweep.
// Source query: binary search (a read state and a compare state per step), then divide.
// One word in flight; the next is accepted from the cycle after the result is taken.
// arst_n clears run count, total and control; table cells are unset until written.
`default_nettype none
module strided_run_index_map import sri_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_word_t in_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output out_word_t     out_data
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_APP  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;
	localparam logic [2:0] S_BRD  = 3'd6;
	localparam logic [2:0] S_BCMP = 3'd7;

	logic [2:0]      state_q;
	in_word_t        req_q;
	logic [CntW-1:0] runs_q;
	logic [IdxW-1:0] total_q;
	logic [IdxW-1:0] stride0_q;
	logic [IdxW-1:0] prod_q;
	run_t            hit_q;
	logic            hitv_q;
	run_t            last_q;

	// binary search over starts: read one cell, compare next cycle
	run_t            rd_q;
	run_t            bs_run_q;
	logic [CntW-1:0] bs_first_q;
	logic [CntW-1:0] bs_cnt_q;
	logic [CntW-1:0] bs_step;
	logic [CntW-1:0] bs_mid;

	scan_t tok [MaxRuns+1];
	run_t  cells [MaxRuns];
	logic  wr_cell [MaxRuns];
	run_t  wr_run;
	logic [PtrW-1:0] last_idx;
	logic [PtrW-1:0] wr_idx;
	logic            wr_en;
	run_t            last_run;

	assign in_stall = (state_q != S_IDLE) || out_valid;
	assign last_idx = PtrW'(runs_q - 1'b1);
	// copy of the last run, kept so appends never index the table
	assign last_run = last_q;
	assign bs_step  = bs_cnt_q >> 1;
	assign bs_mid   = bs_first_q + bs_step;

	// source of the scan chain: launched when a position query is accepted
	assign tok[0] = '{vld: in_valid && !in_stall && in_data.kind == KIND_POS,
		kind: in_data.kind, key: in_data.query_position, hit: 1'b0, run: '0};

	for (genvar i = 0; i < MaxRuns; i++) begin : g_cell
		assign wr_cell[i] = wr_en && (wr_idx == PtrW'(i));
		sri_cell u_cell (
			.clk(clk), .arst_n(arst_n), .wr(wr_cell[i]), .wr_run(wr_run),
			.occupied(CntW'(i) < runs_q), .tok_in(tok[i]), .tok_out(tok[i+1]),
			.run_q(cells[i])
		);
	end

	// divider for source queries
	logic            div_done;
	logic [IdxW-1:0] div_quo, div_rem;
	logic            div_start;
	assign div_start = (state_q == S_BRD) && bs_cnt_q == '0 && bs_first_q != '0
		&& bs_run_q.stride != '0;
	sri_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(req_q.query_source - bs_run_q.start), .den(bs_run_q.stride),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	// append decisions, evaluated in S_APP from stored request
	logic            ovf, can_merge, full;
	logic [IdxW-1:0] run_end;
	assign ovf       = req_q.run_length > (~total_q);
	assign run_end   = last_run.start + prod_q;
	assign can_merge = (runs_q != '0) && last_run.stride == req_q.run_stride
		&& run_end == req_q.run_start;
	assign full      = runs_q >= CntW'(MaxRuns);

	always_comb begin
		wr_en  = 1'b0;
		wr_idx = PtrW'(runs_q);
		wr_run = '{start: req_q.run_start, len: req_q.run_length,
			stride: req_q.run_stride, base: total_q};
		if (state_q == S_APP && req_q.run_length != '0 && !ovf) begin
			if (can_merge) begin
				wr_en  = 1'b1;
				wr_idx = last_idx;
				wr_run = last_run;
				wr_run.len = last_run.len + req_q.run_length;
			end else if (!full) begin
				wr_en = 1'b1;
			end
		end
	end

	out_word_t res;
	always_comb begin
		res = '0;
		res.run_count_out  = 7'(runs_q);
		res.total_out      = total_q;
		res.is_unit_single = (runs_q == '0) || (runs_q == CntW'(1) && stride0_q == IdxW'(1));
	end

	// result word and its load strobe
	out_word_t res_next;
	logic      res_load;
	always_comb begin
		res_next = res;
		res_load = 1'b0;
		unique case (state_q)
			S_IDLE: res_load = in_valid && !in_stall && in_data.kind == KIND_NOP;
			S_APP: begin
				res_load = 1'b1;
				if (req_q.run_length == '0) begin
					res_next.status = ST_OK;
				end else if (ovf) begin
					res_next.status = ST_OVERFLOW;
				end else if (can_merge) begin
					res_next.merged    = 1'b1;
					res_next.total_out = total_q + req_q.run_length;
				end else if (full) begin
					res_next.status = ST_FULL;
				end else begin
					res_next.total_out      = total_q + req_q.run_length;
					res_next.run_count_out  = 7'(runs_q + 1'b1);
					res_next.is_unit_single = (runs_q == '0) &&
						req_q.run_stride == IdxW'(1);
				end
			end
			S_SCAN: begin
				if (tok[MaxRuns].vld && req_q.query_position >= total_q) begin
					res_load        = 1'b1;
					res_next.status = ST_RANGE;
				end
			end
			S_BRD: begin
				if (bs_cnt_q == '0) begin
					if (bs_first_q == '0) begin
						res_load        = 1'b1;
						res_next.status = ST_BEFORE;
					end else if (bs_run_q.stride == '0) begin
						// zero stride: the run is one point
						res_load              = 1'b1;
						res_next.position_out = bs_run_q.base;
						res_next.contained    = req_q.query_source == bs_run_q.start;
					end
				end
			end
			S_OUT: begin
				res_load            = 1'b1;
				res_next.source_out = hit_q.start + prod_q;
			end
			S_DIV: begin
				if (div_done) begin
					res_load              = 1'b1;
					res_next.position_out = hit_q.base + div_quo;
					res_next.contained    = div_rem == '0 && div_quo < hit_q.len;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			runs_q    <= '0;
			total_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (res_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (wr_en) total_q <= total_q + req_q.run_length;
			if (wr_en && !can_merge) runs_q <= runs_q + 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						unique case (in_data.kind)
							KIND_APPEND: state_q <= S_MUL;
							KIND_POS:    state_q <= S_SCAN;
							KIND_SRC:    state_q <= S_BRD;
							KIND_NOP:    state_q <= S_IDLE;
						endcase
					end
				end
				S_MUL: state_q <= S_APP;
				S_APP: state_q <= S_IDLE;
				S_SCAN: begin
					if (tok[MaxRuns].vld) state_q <= res_load ? S_IDLE : S_OUT;
				end
				S_BRD: begin
					if (bs_cnt_q == '0) state_q <= div_start ? S_DIV : S_IDLE;
					else state_q <= S_BCMP;
				end
				S_BCMP: state_q <= S_BRD;
				S_OUT: state_q <= S_IDLE;
				S_DIV: begin
					if (div_done) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !in_stall) begin
			req_q      <= in_data;
			bs_first_q <= '0;
			bs_cnt_q   <= runs_q;
		end
		if (res_load) out_data <= res_next;
		if (state_q == S_IDLE && in_data.kind == KIND_APPEND)
			prod_q <= last_run.len * last_run.stride;
		else if (state_q == S_SCAN && tok[MaxRuns].vld) begin
			hit_q  <= tok[MaxRuns].run;
			hitv_q <= tok[MaxRuns].hit;
			prod_q <= tok[MaxRuns].run.stride * (tok[MaxRuns].key - tok[MaxRuns].run.base);
		end else if (div_start) begin
			hit_q  <= bs_run_q;
			hitv_q <= 1'b1;
		end
		// upper-bound search: move past mid when its start <= source
		if (state_q == S_BRD && bs_cnt_q != '0) rd_q <= cells[PtrW'(bs_mid)];
		if (state_q == S_BCMP) begin
			if (!(req_q.query_source < rd_q.start)) begin
				bs_first_q <= bs_mid + 1'b1;
				bs_cnt_q   <= bs_cnt_q - bs_step - 1'b1;
				bs_run_q   <= rd_q;
			end else begin
				bs_cnt_q <= bs_step;
			end
		end
		if (wr_en) last_q <= wr_run;
		if (wr_en && wr_idx == '0) stride0_q <= wr_run.stride;
	end

	// the multiply before an append must see the last run unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |=> $stable(runs_q)) else $error("runs changed before append");
	assert property (@(posedge clk) disable iff (!arst_n)
		runs_q <= CntW'(MaxRuns)) else $error("run count beyond table");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> !in_stall == 1'b0) else $error("input open during divide");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV) else $error("divider done outside divide");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |-> hitv_q) else $error("position result without run");
endmodule
`default_nettype wire

>>> tb/sv/strided_run_index_map_test.sv
// Testbench: strided run index map checked against a run-table scoreboard.
`default_nettype none
module strided_run_index_map_test;
	import sri_pkg::*;

	// Scoreboard: mirrors the run table, predicts each result word, checks in order.
	class run_table_board;
		logic [IdxW-1:0] starts [MaxRuns];
		logic [IdxW-1:0] lens [MaxRuns];
		logic [IdxW-1:0] strides [MaxRuns];
		logic [IdxW-1:0] bases [MaxRuns];
		int unsigned held;
		logic [IdxW-1:0] total;
		out_word_t pending[$];
		int unsigned mismatches;

		function new();
			held = 0;
			total = '0;
			mismatches = 0;
		endfunction

		// source index just past the last run
		function logic [IdxW-1:0] tail_end();
			logic [IdxW-1:0] e;
			e = '0;
			if (held > 0)
				e = starts[held-1] + lens[held-1] * strides[held-1];
			return e;
		endfunction

		// accepted input: update the table copy and queue the expected word
		function void note_input(in_word_t w);
			out_word_t r;
			int unsigned k, first, cnt, step, mid;
			logic [IdxW-1:0] off, qt;
			r = '0;
			case (w.kind)
				KIND_APPEND: begin
					if (w.run_length == 0) begin
						r.status = ST_OK;
					end else if (w.run_length > ({IdxW{1'b1}} - total)) begin
						r.status = ST_OVERFLOW;
					end else if (held > 0 && strides[held-1] == w.run_stride &&
							tail_end() == w.run_start) begin
						lens[held-1] = lens[held-1] + w.run_length;
						total = total + w.run_length;
						r.merged = 1'b1;
					end else if (held >= MaxRuns) begin
						r.status = ST_FULL;
					end else begin
						starts[held] = w.run_start;
						lens[held] = w.run_length;
						strides[held] = w.run_stride;
						bases[held] = total;
						held++;
						total = total + w.run_length;
					end
				end
				KIND_POS: begin
					if (w.query_position >= total) begin
						r.status = ST_RANGE;
					end else begin
						k = 0;
						for (int i = 0; i < held; i++)
							if (bases[i] <= w.query_position)
								k = i;
						r.source_out = starts[k] + strides[k] * (w.query_position - bases[k]);
					end
				end
				KIND_SRC: begin
					// upper-bound search over starts in table order
					first = 0;
					cnt = held;
					while (cnt > 0) begin
						step = cnt / 2;
						mid = first + step;
						if (!(w.query_source < starts[mid])) begin
							first = mid + 1;
							cnt -= step + 1;
						end else begin
							cnt = step;
						end
					end
					if (first == 0) begin
						r.status = ST_BEFORE;
					end else begin
						k = first - 1;
						off = w.query_source - starts[k];
						if (strides[k] == 0) begin
							r.contained = (off == 0);
							r.position_out = bases[k];
						end else begin
							qt = off / strides[k];
							r.contained = (off % strides[k] == 0) && (qt < lens[k]);
							r.position_out = bases[k] + qt;
						end
					end
				end
				default: ;
			endcase
			r.run_count_out = held[6:0];
			r.total_out = total;
			r.is_unit_single = (held == 0) || (held == 1 && strides[0] == 1);
			pending = {pending, r};
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp src=%h pos=%h c=%b st=%0d m=%b n=%0d tot=%h u=%b",
						exp.source_out, exp.position_out, exp.contained, exp.status,
						exp.merged, exp.run_count_out, exp.total_out, exp.is_unit_single);
					$display("          got src=%h pos=%h c=%b st=%0d m=%b n=%0d tot=%h u=%b",
						got.source_out, got.position_out, got.contained, got.status,
						got.merged, got.run_count_out, got.total_out, got.is_unit_single);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_data;
	logic out_valid;
	logic out_stall;
	out_word_t out_data;

	run_table_board board;
	int unsigned cycle_no = 0;

	// a long quiet window on both sides: no gaps, no stalls
	localparam int unsigned QuietLo = 12000;
	localparam int unsigned QuietHi = 22000;

	strided_run_index_map dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #1 clk = ~clk;

	function automatic bit quiet();
		return cycle_no >= QuietLo && cycle_no < QuietHi;
	endfunction

	// receiver: take results, stall about 36% of cycles outside the quiet window
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result(out_data);
			out_stall <= !quiet() && ($urandom_range(0, 99) < 36);
		end
	end

	function automatic in_word_t mk(logic [1:0] k, logic [IdxW-1:0] st, logic [IdxW-1:0] ln,
			logic [IdxW-1:0] sd, logic [IdxW-1:0] qp, logic [IdxW-1:0] qs);
		in_word_t w;
		w.kind = k;
		w.run_start = st;
		w.run_length = ln;
		w.run_stride = sd;
		w.query_position = qp;
		w.query_source = qs;
		return w;
	endfunction

	// one word out: optional gaps, then hold valid until taken
	task automatic send_word(in_word_t w);
		while (!quiet() && $urandom_range(0, 99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		board.note_input(w);
	endtask

	// random word, shaped from the current table so queries land on runs
	function automatic in_word_t rand_word();
		in_word_t w;
		int unsigned pick, k;
		w = mk(KIND_APPEND, $urandom, $urandom, $urandom, $urandom, $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			w.kind = 2'($urandom_range(0, 3));  // noise
		end else if (pick < 45) begin
			w.kind = KIND_APPEND;
			if (board.held > 0 && $urandom_range(0, 2) == 0) begin
				w.run_start = board.tail_end();
				w.run_stride = board.strides[board.held-1];
			end else begin
				w.run_start = board.tail_end() + $urandom_range(1, 1000);
				case ($urandom_range(0, 3))
					0: w.run_stride = 0;
					1: w.run_stride = 1;
					2: w.run_stride = $urandom_range(2, 9);
					default: w.run_stride = $urandom;
				endcase
			end
			case ($urandom_range(0, 99))
				0: w.run_length = $urandom;
				1, 2: w.run_length = 0;
				default: w.run_length = $urandom_range(1, 64);
			endcase
		end else if (pick < 70) begin
			w.kind = KIND_POS;
			if (board.total != 0 && $urandom_range(0, 4) != 0)
				w.query_position = $urandom_range(0, board.total - 1);
			else
				w.query_position = board.total + $urandom_range(0, 3);
		end else begin
			w.kind = KIND_SRC;
			if (board.held > 0 && $urandom_range(0, 4) != 0) begin
				k = $urandom_range(0, board.held - 1);
				w.query_source = board.starts[k] +
					board.strides[k] * $urandom_range(0, 70);
				if ($urandom_range(0, 2) == 0)
					w.query_source = w.query_source + $urandom_range(0, 4) - 2;
			end
		end
		return w;
	endfunction

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, zero length, unit run, merge, point run, overflow, no-op
		send_word(mk(KIND_POS, 0, 0, 0, 0, 0));
		send_word(mk(KIND_SRC, 0, 0, 0, 0, 0));
		send_word(mk(KIND_SRC, 0, 0, 0, 0, 32'hFFFF_FFFF));
		send_word(mk(KIND_APPEND, 100, 0, 1, 0, 0));
		send_word(mk(KIND_APPEND, 100, 10, 1, 0, 0));
		send_word(mk(KIND_APPEND, 110, 5, 1, 0, 0));          // merges
		send_word(mk(KIND_SRC, 0, 0, 0, 0, 99));              // before first run
		send_word(mk(KIND_SRC, 0, 0, 0, 0, 114));
		send_word(mk(KIND_APPEND, 200, 3, 0, 0, 0));          // single point run
		send_word(mk(KIND_APPEND, 200, 2, 0, 0, 0));          // zero stride, continues
		send_word(mk(KIND_SRC, 0, 0, 0, 0, 200));
		send_word(mk(KIND_SRC, 0, 0, 0, 0, 201));
		send_word(mk(KIND_APPEND, 300, 4, 7, 0, 0));
		send_word(mk(KIND_SRC, 0, 0, 0, 0, 314));
		send_word(mk(KIND_SRC, 0, 0, 0, 0, 315));
		send_word(mk(KIND_SRC, 0, 0, 0, 0, 32'hFFFF_FFFF));
		send_word(mk(KIND_POS, 0, 0, 0, 0, 0));
		send_word(mk(KIND_POS, 0, 0, 0, 16, 0));
		send_word(mk(KIND_POS, 0, 0, 0, 23, 0));               // last position in range
		send_word(mk(KIND_POS, 0, 0, 0, 32'hFFFF_FFFF, 0));
		send_word(mk(KIND_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
		send_word(mk(KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_word(mk(KIND_APPEND, 32'h8000_0000, 1, 32'h8000_0000, 0, 0));

		// random part; sender drains the block once, after the first 300 words
		for (int i = 0; i < 1130; i++) begin
			if (i == 300) begin
				in_valid <= 1'b0;
				while (board.pending.size() != 0) @(posedge clk);
			end
			send_word(rand_word());
		end
		in_valid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("PASS strided_run_index_map");
		end else begin
			$display("FAIL strided_run_index_map");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("FAIL strided_run_index_map");
		$finish;
	end
endmodule
`default_nettype wire

>>> strided_run_index_map.f
sv/sri_pkg.sv
sv/sri_cell.sv
sv/sri_div.sv
sv/strided_run_index_map.sv
tb/sv/strided_run_index_map_test.sv
